[src/egcd_pkg.sv]
// ----------------------------------------------------------------------------
// egcd_pkg: shared types and constants of the Euclidean GCD engine
// Transaction payload structs, the default datapath width, and the
// control and status structs passed between the top level and the core.
// ----------------------------------------------------------------------------
package egcd_pkg;

	// Width of every operand and result data field on the ports.
	localparam int FIELD_WIDTH = 32;

	// Default width of the internal datapath.
	localparam int WORD_WIDTH_DEFAULT = 32;

	typedef struct packed {
		logic [FIELD_WIDTH-1:0] first_operand;
		logic [FIELD_WIDTH-1:0] second_operand;
	} operand_item_t;

	typedef struct packed {
		logic [FIELD_WIDTH-1:0] divisor_result;
		logic                   zero_divisor_flag;
	} result_item_t;

	// Commands from the top level to the core.
	typedef struct packed {
		logic start;   // load a new operand pair and begin
		logic drain;   // finished result has been taken, return to idle
	} core_ctrl_t;

	// Status from the core to the top level.
	typedef struct packed {
		logic busy;    // a pair is loaded, result not yet taken
		logic done;    // result is valid on the core output
	} core_stat_t;

endpackage

[src/egcd_core.sv]
// ----------------------------------------------------------------------------
// egcd_core: iterative GCD datapath and sequencer
// Binary GCD over one shared compare and subtract unit: each cycle either
// halves even operands or replaces the larger odd operand by half the
// difference. The common power of two is counted and restored at the end.
// ----------------------------------------------------------------------------
module egcd_core import egcd_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  core_ctrl_t            ctrl,
	input  logic [WORD_WIDTH-1:0] a_init,
	input  logic [WORD_WIDTH-1:0] b_init,
	output core_stat_t            stat,
	output logic [WORD_WIDTH-1:0] gcd
);

	localparam int SHIFT_WIDTH = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                   state_q;
	logic [WORD_WIDTH-1:0]  a_q;
	logic [WORD_WIDTH-1:0]  b_q;
	logic [SHIFT_WIDTH-1:0] k_q;

	logic                   finish;
	logic                   a_ge_b;
	logic [WORD_WIDTH-1:0]  big;
	logic [WORD_WIDTH-1:0]  little;
	logic [WORD_WIDTH-1:0]  mag;
	logic [WORD_WIDTH:0]    sum;

	// The loop ends as soon as one operand reaches zero; the other then
	// holds the GCD divided by the counted power of two.
	assign finish = (a_q == '0) || (b_q == '0);

	// The single shared compare and subtract unit.
	assign a_ge_b = (a_q >= b_q);
	assign big    = a_ge_b ? a_q : b_q;
	assign little = a_ge_b ? b_q : a_q;
	assign mag    = big - little;

	assign sum = {1'b0, a_q} + {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (ctrl.start) begin
			state_q <= ST_RUN;
		end else if (state_q == ST_RUN && finish && ctrl.drain) begin
			state_q <= ST_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			a_q <= a_init;
			b_q <= b_init;
			k_q <= '0;
		end else if (state_q == ST_RUN && !finish) begin
			priority if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_ge_b) begin
				// Difference of two odd values is even, so halve it at once.
				a_q <= mag >> 1;
			end else begin
				b_q <= mag >> 1;
			end
		end
	end

	assign stat.busy = (state_q == ST_RUN);
	assign stat.done = (state_q == ST_RUN) && finish;
	assign gcd       = (a_q | b_q) << k_q;

	a_common_twos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && !finish && !a_q[0] && !b_q[0] && !ctrl.start)
		|=> k_q == $past(k_q) + 1'b1)
		else $error("common factor of two not counted");

	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && !finish && !ctrl.start) |=> sum < $past(sum))
		else $error("operand sum did not decrease");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> (state_q == ST_RUN) && (k_q == '0))
		else $error("start did not load a fresh pair");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> state_q == ST_IDLE)
		else $error("start while a pair is in progress");

endmodule

[src/euclidean_gcd_engine.sv]
// ----------------------------------------------------------------------------
// euclidean_gcd_engine: greatest common divisor of two unsigned words
// Top level with the operand and result channels and the output register.
// ----------------------------------------------------------------------------
// Each operand transaction carries two unsigned integers and yields exactly
// one result transaction holding their greatest common divisor. When the
// second operand is zero the result is the first operand and the zero
// divisor flag is set; when both are zero the result is zero. Operands are
// taken at WORD_WIDTH bits (low bits kept when WORD_WIDTH is below the port
// width). The answer is computed by a binary GCD on one shared compare and
// subtract unit: a pair is loaded, then the loop runs, every loop step
// removing at least one bit from one operand, and finally the answer moves
// into the output register. The core is busy for that whole time and
// operands_ready stays low meanwhile. The output register lets a new pair
// be loaded while the previous result is still waiting for result_ready.
// Nothing is kept between pairs.
// ----------------------------------------------------------------------------
module euclidean_gcd_engine import egcd_pkg::*; #(
	parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          operands_valid,
	output logic          operands_ready,
	input  operand_item_t operands,
	output logic          result_valid,
	input  logic          result_ready,
	output result_item_t  result
);

	core_ctrl_t            ctrl;
	core_stat_t            stat;
	logic [WORD_WIDTH-1:0] a_init;
	logic [WORD_WIDTH-1:0] b_init;
	logic [WORD_WIDTH-1:0] gcd;

	logic                  flag_q;
	logic                  result_valid_q;
	result_item_t          result_q;
	logic                  load_out;

	// The core takes a new pair whenever it is not holding one.
	assign operands_ready = !stat.busy;
	assign ctrl.start     = operands_valid && operands_ready;

	assign a_init = WORD_WIDTH'(operands.first_operand);
	assign b_init = WORD_WIDTH'(operands.second_operand);

	// A finished answer moves to the output register when that register is
	// empty or is being emptied in this same cycle.
	assign load_out   = stat.done && (!result_valid_q || result_ready);
	assign ctrl.drain = load_out;

	egcd_core #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.a_init (a_init),
		.b_init (b_init),
		.stat   (stat),
		.gcd    (gcd)
	);

	// The zero divisor flag is decided at acceptance. The binary loop with a
	// zero second operand finishes at once with the first operand as answer.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			flag_q <= (b_init == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.divisor_result    <= FIELD_WIDTH'(gcd);
			result_q.zero_divisor_flag <= flag_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
